// ----- hdl/prpc_pkg.sv -----
package prpc_pkg;

    // Table size default
    localparam int RULE_COUNT_DEF = 128;

    // Stream widths
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 8;

    // Field widths
    localparam int INDEX_W = 7;
    localparam int PRIO_W  = 32;
    localparam int IP_W    = 32;
    localparam int PLEN_W  = 6;
    localparam int PROTO_W = 8;
    localparam int PORT_W  = 16;
    localparam int LEN_W   = 16;

    // Priority that is never selected; also the starting best value
    localparam logic [PRIO_W-1:0] PRIO_NONE = {PRIO_W{1'b1}};
    localparam logic [PLEN_W-1:0] PREFIX_MAX = PLEN_W'(IP_W);

    // Request kinds carried in tuser
    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_WRITE    = 1'b1;

    // One rule as held in a cell (active bit kept apart, it is reset)
    typedef struct packed {
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    mask;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic [LEN_W-1:0]   ceiling;
        logic [PRIO_W-1:0]  prio;
        logic               drop_action;
    } rule_t;

    // Request travelling along the cell row, with the running best match
    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] rule_index;
        logic [PRIO_W-1:0]  prio;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    mask;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic [LEN_W-1:0]   length;
        logic               drop_action;
        logic               active;
        logic               is_ipv4;
        logic [PRIO_W-1:0]  best;
        logic               verdict;
    } token_t;

    // Mask over the leading address bits for a prefix length
    function automatic logic [IP_W-1:0] lead_mask(input logic [PLEN_W-1:0] plen);
        logic [IP_W-1:0] m;
        if (plen == '0)
        begin
            m = '0;
        end
        else if (plen >= PREFIX_MAX)
        begin
            m = {IP_W{1'b1}};
        end
        else
        begin
            m = {IP_W{1'b1}} << (PREFIX_MAX - plen);
        end
        return m;
    endfunction

endpackage

// ----- hdl/priority_rule_packet_classifier_core.sv -----
// Priority rule packet classifier. Each of RULE_COUNT cells holds one filter
// rule (priority, source prefix, protocol, port, length ceiling, action);
// a request walks the row of cells one cell per cycle. A write request lands
// in the cell whose index it names (indexes at or above RULE_COUNT are
// dropped); a classify request carries the best match found so far and
// leaves with the action of the lowest-priority matching rule, lower index on
// a tie, or default_drop when none matches; a non-IPv4 packet always gets a
// forward verdict. The row takes a new request every cycle while the output
// is free. m_axis_tvalid for a classify verdict rises when its request, having
// passed through the register of each cell of the row in turn, is loaded into
// the output register, which the last cell feeds directly. Writes give no
// output. A stalled output holds the whole row. default_drop may only be
// changed while no request is in flight.
module priority_rule_packet_classifier_core #(
    parameter int RULE_COUNT = prpc_pkg::RULE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,    // default_drop
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // rule_index[6:0], priority_req[38:7], src_ip[70:39], src_plen[76:71],
    // proto[84:77], l4_port[100:85], length[116:101], drop_action[117],
    // active[118], is_ipv4[119]
    input  logic [prpc_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,   // op[0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [prpc_pkg::M_DATA_W-1:0] m_axis_tdata    // drop[0], zeros above
);

    logic             default_drop_reg;
    logic             advance;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_drop_reg;
    prpc_pkg::token_t entry_tok;
    logic             chain_valid [RULE_COUNT+1];
    prpc_pkg::token_t chain_tok   [RULE_COUNT+1];

    // Hold the default verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_drop_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            default_drop_reg <= cfg_wr_data;
        end
    end

    // Move the row whenever the output register is free or being emptied
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Unpack the request and seed the running best match
    always_comb
    begin
        entry_tok.op          = s_axis_tuser[0];
        entry_tok.rule_index  = s_axis_tdata[6:0];
        entry_tok.prio        = s_axis_tdata[38:7];
        entry_tok.src_ip      = s_axis_tdata[70:39];
        entry_tok.mask        = prpc_pkg::lead_mask(s_axis_tdata[76:71]);
        entry_tok.proto       = s_axis_tdata[84:77];
        entry_tok.port        = s_axis_tdata[100:85];
        entry_tok.length      = s_axis_tdata[116:101];
        entry_tok.drop_action = s_axis_tdata[117];
        entry_tok.active      = s_axis_tdata[118];
        entry_tok.is_ipv4     = s_axis_tdata[119];
        entry_tok.best        = prpc_pkg::PRIO_NONE;
        entry_tok.verdict     = s_axis_tdata[119] ? default_drop_reg : 1'b0;
    end

    assign chain_valid[0] = s_axis_tvalid;
    assign chain_tok[0]   = entry_tok;

    // Row of rule cells
    for (genvar gi = 0; gi < RULE_COUNT; gi++)
    begin : g_cell
        prpc_cell #(
            .CELL_INDEX (gi)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[gi]),
            .in_tok    (chain_tok[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_tok   (chain_tok[gi+1])
        );
    end

    // Keep only classify results for the output register
    assign out_valid_next = chain_valid[RULE_COUNT]
                            && (chain_tok[RULE_COUNT].op == prpc_pkg::OP_CLASSIFY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_drop_reg <= chain_tok[RULE_COUNT].verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(prpc_pkg::M_DATA_W-1){1'b0}}, out_drop_reg};

`ifndef SYNTHESIS
    // A non-IPv4 packet leaves the row with a forward verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[RULE_COUNT] && (chain_tok[RULE_COUNT].op == prpc_pkg::OP_CLASSIFY)
         && !chain_tok[RULE_COUNT].is_ipv4) |-> !chain_tok[RULE_COUNT].verdict)
        else $error("non-IPv4 packet reached the output with a drop verdict");

    // An IPv4 packet with no matching rule leaves with the default verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[RULE_COUNT] && (chain_tok[RULE_COUNT].op == prpc_pkg::OP_CLASSIFY)
         && chain_tok[RULE_COUNT].is_ipv4
         && (chain_tok[RULE_COUNT].best == prpc_pkg::PRIO_NONE))
        |-> (chain_tok[RULE_COUNT].verdict == default_drop_reg))
        else $error("unmatched packet verdict differs from default");

    // A new result only comes from a classify request at the end of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(chain_valid[RULE_COUNT]
            && (chain_tok[RULE_COUNT].op == prpc_pkg::OP_CLASSIFY)))
        else $error("result produced without a classify request");

    // A stalled row holds its last request
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_valid[RULE_COUNT]))
        else $error("cell row moved while the output was stalled");
`endif

endmodule

// ----- hdl/prpc_cell.sv -----
module prpc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  prpc_pkg::token_t in_tok,
    output logic            out_valid,
    output prpc_pkg::token_t out_tok
);

    logic             valid_reg;
    prpc_pkg::token_t tok_reg;
    prpc_pkg::token_t tok_next;
    logic             active_reg;
    logic             active_next;
    prpc_pkg::rule_t  rule_reg;
    prpc_pkg::rule_t  rule_next;
    logic             wr_sel;
    logic             hit;

    // Capture a write request addressed to this slot
    always_comb
    begin
        wr_sel = in_valid && (in_tok.op == prpc_pkg::OP_WRITE)
                 && (int'(in_tok.rule_index) == CELL_INDEX);
        active_next = active_reg;
        rule_next   = rule_reg;
        if (wr_sel)
        begin
            active_next          = in_tok.active;
            rule_next.src_ip     = in_tok.src_ip;
            rule_next.mask       = in_tok.mask;
            rule_next.proto      = in_tok.proto;
            rule_next.port       = in_tok.port;
            rule_next.ceiling    = in_tok.length;
            rule_next.prio       = in_tok.prio;
            rule_next.drop_action = in_tok.drop_action;
        end
    end

    // Match the held rule against a passing classify request
    always_comb
    begin
        hit = in_valid && (in_tok.op == prpc_pkg::OP_CLASSIFY) && in_tok.is_ipv4
              && active_reg
              && (((rule_reg.src_ip ^ in_tok.src_ip) & rule_reg.mask) == '0)
              && ((rule_reg.proto == '0) || (rule_reg.proto == in_tok.proto))
              && ((rule_reg.ceiling == '0) || (in_tok.length <= rule_reg.ceiling))
              && ((rule_reg.port == '0)
                  || ((in_tok.port != '0) && (rule_reg.port == in_tok.port)))
              && (rule_reg.prio < in_tok.best);
        tok_next = in_tok;
        if (hit)
        begin
            tok_next.best    = rule_reg.prio;
            tok_next.verdict = rule_reg.drop_action;
        end
    end

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg  <= in_valid;
            active_reg <= active_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg  <= tok_next;
            rule_reg <= rule_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ----- bench/tb_priority_rule_packet_classifier_core.sv -----
`timescale 1ns / 1ps

module tb_priority_rule_packet_classifier_core;

    localparam int RULES = prpc_pkg::RULE_COUNT_DEF;
    localparam int RANDOM_PER_PHASE = 475;
    localparam int PHASES = 4;

    // One request as the sender sees it
    typedef struct {
        logic                         op;
        logic [prpc_pkg::INDEX_W-1:0] rule_index;
        logic [prpc_pkg::PRIO_W-1:0]  prio;
        logic [prpc_pkg::IP_W-1:0]    src_ip;
        logic [prpc_pkg::PLEN_W-1:0]  src_plen;
        logic [prpc_pkg::PROTO_W-1:0] proto;
        logic [prpc_pkg::PORT_W-1:0]  l4_port;
        logic [prpc_pkg::LEN_W-1:0]   length;
        logic                         drop_action;
        logic                         active;
        logic                         is_ipv4;
    } acl_request_t;

    // One stored filter rule
    typedef struct {
        logic                         active;
        logic [prpc_pkg::IP_W-1:0]    src_ip;
        logic [prpc_pkg::PLEN_W-1:0]  src_plen;
        logic [prpc_pkg::PROTO_W-1:0] proto;
        logic [prpc_pkg::PORT_W-1:0]  port;
        logic [prpc_pkg::LEN_W-1:0]   ceiling;
        logic [prpc_pkg::PRIO_W-1:0]  prio;
        logic                         drop_action;
    } acl_rule_t;

    // Rule table shadow, verdict predictor and the queue of verdicts still owed
    class acl_verdict_board;
        acl_rule_t rules [RULES];
        logic      default_drop;
        logic      verdicts_due [$];
        int        errors;

        function new();
            foreach (rules[i])
            begin
                rules[i] = '{default: '0};
            end
            default_drop = 1'b0;
            errors = 0;
        endfunction

        function void set_default(logic value);
            default_drop = value;
        endfunction

        // Leading-bit mask for a stored (already clamped) prefix length
        function logic [prpc_pkg::IP_W-1:0] source_mask(logic [prpc_pkg::PLEN_W-1:0] plen);
            if (plen == '0)
            begin
                return '0;
            end
            return ~({prpc_pkg::IP_W{1'b1}} >> plen);
        endfunction

        // Apply a write or predict the verdict of a classify request
        function void note_request(acl_request_t req);
            logic [prpc_pkg::PRIO_W-1:0] best;
            logic                        verdict;
            logic [prpc_pkg::IP_W-1:0]   mask;
            acl_rule_t                   r;
            if (req.op == prpc_pkg::OP_WRITE)
            begin
                r.active      = req.active;
                r.src_ip      = req.src_ip;
                r.src_plen    = (req.src_plen > prpc_pkg::PREFIX_MAX) ? prpc_pkg::PREFIX_MAX
                                                                      : req.src_plen;
                r.proto       = req.proto;
                r.port        = req.l4_port;
                r.ceiling     = req.length;
                r.prio        = req.prio;
                r.drop_action = req.drop_action;
                if (int'(req.rule_index) < RULES)
                begin
                    rules[req.rule_index] = r;
                end
                return;
            end
            best = prpc_pkg::PRIO_NONE;
            verdict = default_drop;
            if (!req.is_ipv4)
            begin
                verdict = 1'b0;
            end
            else
            begin
                for (int i = 0; i < RULES; i++)
                begin
                    r = rules[i];
                    mask = source_mask(r.src_plen);
                    if (!r.active)
                        continue;
                    if ((r.src_ip & mask) != (req.src_ip & mask))
                        continue;
                    if (r.proto != '0 && r.proto != req.proto)
                        continue;
                    if (r.ceiling != '0 && req.length > r.ceiling)
                        continue;
                    if (r.port != '0 && (req.l4_port == '0 || r.port != req.l4_port))
                        continue;
                    // strict compare: lower index keeps a tie, all-ones never wins
                    if (r.prio < best)
                    begin
                        best = r.prio;
                        verdict = r.drop_action;
                    end
                end
            end
            verdicts_due.push_back(verdict);
        endfunction

        // Compare one output verdict with the oldest one owed
        function void check_verdict(logic [prpc_pkg::M_DATA_W-1:0] data);
            logic expected;
            if (verdicts_due.size() == 0)
            begin
                $error("drop: no verdict expected, actual %0d", data[0]);
                errors++;
                return;
            end
            expected = verdicts_due.pop_front();
            if (data[0] !== expected)
            begin
                $error("drop: expected %0d, actual %0d", expected, data[0]);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void flag_leftover();
            if (verdicts_due.size() != 0)
            begin
                $error("drop: %0d verdicts never arrived", verdicts_due.size());
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic                            cfg_wr_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [prpc_pkg::S_DATA_W-1:0]   s_axis_tdata;
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [prpc_pkg::M_DATA_W-1:0]   m_axis_tdata;

    acl_verdict_board board;
    bit               jitter;

    priority_rule_packet_classifier_core #(
        .RULE_COUNT (RULES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!jitter || r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Present one request, hold it until accepted, then record it
    task automatic send_request(acl_request_t req);
        int gap;
        gap = idle_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {req.is_ipv4, req.active, req.drop_action, req.length, req.l4_port,
                          req.proto, req.src_plen, req.src_ip, req.prio, req.rule_index};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.note_request(req);
    endtask

    // Write one rule; is_ipv4 carries noise since the block ignores it
    task automatic send_rule(int slot, logic [31:0] prio, logic [31:0] ip, logic [5:0] plen,
                             logic [7:0] proto, logic [15:0] port, logic [15:0] ceiling,
                             logic drop_action, logic active);
        acl_request_t req;
        req.op          = prpc_pkg::OP_WRITE;
        req.rule_index  = prpc_pkg::INDEX_W'(slot);
        req.prio        = prio;
        req.src_ip      = ip;
        req.src_plen    = plen;
        req.proto       = proto;
        req.l4_port     = port;
        req.length      = ceiling;
        req.drop_action = drop_action;
        req.active      = active;
        req.is_ipv4     = 1'($urandom);
        send_request(req);
    endtask

    // Classify one packet; rule-only fields carry noise
    task automatic send_packet(logic [31:0] ip, logic [7:0] proto, logic [15:0] port,
                               logic [15:0] length, logic is_ipv4);
        acl_request_t req;
        req.op          = prpc_pkg::OP_CLASSIFY;
        req.rule_index  = prpc_pkg::INDEX_W'($urandom);
        req.prio        = $urandom;
        req.src_ip      = ip;
        req.src_plen    = prpc_pkg::PLEN_W'($urandom);
        req.proto       = proto;
        req.l4_port     = port;
        req.length      = length;
        req.drop_action = 1'($urandom);
        req.active      = 1'($urandom);
        req.is_ipv4     = is_ipv4;
        send_request(req);
    endtask

    // Change default_drop while nothing is in flight
    task automatic write_default(logic value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_default(value);
    endtask

    // Hold the sender until every verdict is back and the row has emptied
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (RULES + 8) @(posedge clk);
    endtask

    // Directed corner cases: empty table, prefix on leading bits, bounds, ties
    task automatic run_directed();
        send_packet(32'h0A00_0001, 8'd6, 16'd80, 16'd64, 1'b1);
        send_packet(32'h0A00_0001, 8'd6, 16'd80, 16'd64, 1'b0);
        send_rule(0, 32'd10, 32'hC0A8_0100, 6'd24, 8'd6, 16'd80, 16'd1500, 1'b0, 1'b1);
        send_packet(32'hC0A8_01FF, 8'd6, 16'd80, 16'd1500, 1'b1);
        send_packet(32'hC0A8_01FF, 8'd6, 16'd80, 16'd1501, 1'b1);
        send_packet(32'hC0A8_0101, 8'd6, 16'd0, 16'd100, 1'b1);
        send_packet(32'hC0A8_0201, 8'd6, 16'd80, 16'd100, 1'b1);
        send_packet(32'h0001_A8C0, 8'd6, 16'd80, 16'd100, 1'b1);
        send_packet(32'hC0A8_0101, 8'd17, 16'd80, 16'd0, 1'b1);
        // wildcard rule at the same priority: lower index must keep the tie
        send_rule(RULES - 1, 32'd10, 32'h0, 6'd0, 8'd0, 16'd0, 16'd0, 1'b1, 1'b1);
        send_packet(32'hC0A8_0180, 8'd6, 16'd80, 16'd0, 1'b1);
        send_packet(32'h1234_5678, 8'd0, 16'd0, 16'hFFFF, 1'b1);
        // overlong prefix clamps to a full match on the address
        send_rule(5, 32'd0, 32'hFFFF_FFFF, 6'd63, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_packet(32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        send_packet(32'hFFFF_FFFE, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
        send_packet(32'hFFFF_FFFF, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
        // all-ones priority never wins, inactive rules never match
        send_rule(RULES - 1, 32'hFFFF_FFFF, 32'h0, 6'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b1);
        send_packet(32'h0505_0505, 8'd1, 16'd7, 16'd9, 1'b1);
        send_rule(1, 32'd0, 32'h0, 6'd0, 8'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        send_packet(32'h0505_0505, 8'd1, 16'd7, 16'd9, 1'b1);
        send_packet(32'hC0A8_0101, 8'd6, 16'd80, 16'd1, 1'b1);
        send_rule(2, 32'h0, 32'h8000_0000, 6'd1, 8'd0, 16'd0, 16'd0, 1'b1, 1'b1);
        send_packet(32'h8000_0000, 8'd0, 16'd0, 16'd0, 1'b1);
        send_packet(32'h7FFF_FFFF, 8'd0, 16'd0, 16'd0, 1'b1);
    endtask

    // Random rule write; priorities cluster low so ties and overrides occur
    task automatic send_random_rule(bit noise);
        int          r;
        logic [31:0] prio;
        logic [5:0]  plen;
        r = $urandom_range(0, 99);
        prio = (r < 40) ? 32'($urandom_range(0, 7)) :
               (r < 90) ? 32'($urandom) : prpc_pkg::PRIO_NONE;
        plen = (noise || $urandom_range(0, 9) < 3) ? 6'($urandom) : 6'($urandom_range(0, 32));
        send_rule($urandom_range(0, RULES - 1), prio, $urandom, plen,
                  (noise || $urandom_range(0, 1)) ? 8'($urandom) : 8'd0,
                  (noise || $urandom_range(0, 1)) ? 16'($urandom) : 16'd0,
                  (noise || $urandom_range(0, 1)) ? 16'($urandom) : 16'd0,
                  1'($urandom), noise ? 1'($urandom) : ($urandom_range(0, 9) < 8));
    endtask

    // Packet built to hit a stored rule, now and then nudged just past it
    task automatic send_aimed_packet();
        acl_rule_t   r;
        logic [31:0] mask;
        logic [31:0] ip;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [15:0] length;
        int          miss;
        r = board.rules[$urandom_range(0, RULES - 1)];
        mask = board.source_mask(r.src_plen);
        ip = (r.src_ip & mask) | ($urandom & ~mask);
        proto = (r.proto != '0) ? r.proto : 8'($urandom);
        port = (r.port != '0) ? r.port : 16'($urandom_range(0, 3) == 0 ? 0 : $urandom);
        length = (r.ceiling != '0) ? 16'($urandom_range(0, r.ceiling)) : 16'($urandom);
        miss = $urandom_range(0, 19);
        unique case (miss)
            0: length = r.ceiling + 16'd1;
            1: port = '0;
            2: proto = proto + 8'd1;
            3: ip = ip ^ (32'h8000_0000 >> $urandom_range(0, 31));
            default: ;
        endcase
        send_packet(ip, proto, port, length, $urandom_range(0, 9) != 0);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            send_random_rule(1'b0);
        end
        else if (r < 85)
        begin
            send_aimed_packet();
        end
        else if (r < 95)
        begin
            send_packet($urandom, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        end
        else
        begin
            send_random_rule(1'b1);
        end
    endtask

    // Compare every verdict taken from the output
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            board.check_verdict(m_axis_tdata);
        end
    end

    // Output back-pressure: runs of ready broken by stalls
    initial
    begin
        int   hold;
        logic ready;
        hold = 0;
        ready = 1'b1;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (jitter && $urandom_range(0, 99) < 30)
            begin
                ready = 1'b0;
                hold = idle_len();
            end
            else
            begin
                ready = 1'b1;
                hold = $urandom_range(0, 10);
            end
            m_axis_tready <= ready;
        end
    end

    // Guard against a hung run
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int waited;
        board = new();
        jitter = 1'b1;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_default(1'b1);
        run_directed();

        // Random phases: default flips each phase, one phase runs without idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            write_default(1'(phase));
            jitter = (phase != 2);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_random();
            end
        end

        // Drain the remaining verdicts, then let the row empty
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 200_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (RULES + 16) @(posedge clk);
        board.flag_leftover();
        if (board.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
